/* sv/bhcs_pkg.sv */
// ----------------------------------------------------------------------------
// bhcs_pkg: shared types and tables for Hall commutation and speed counting
// Transaction structs, op codes and the six-step lookup tables.
// ----------------------------------------------------------------------------
package bhcs_pkg;

    typedef enum logic [1:0] {
        OP_DRIVE = 2'd0,
        OP_HALL  = 2'd1,
        OP_TICK  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0] op;
        logic [2:0] hall;
        logic [7:0] drive_magnitude;
        logic       drive_reverse;
    } t_in_item;

    typedef struct packed {
        logic [7:0] a_high_duty;
        logic       a_low_on;
        logic [7:0] b_high_duty;
        logic       b_low_on;
        logic [7:0] c_high_duty;
        logic       c_low_on;
        logic [2:0] phase_now;
        logic       step_moved;
        logic       step_reverse;
        logic [7:0] speed_magnitude;
        logic       speed_reverse;
        logic       speed_report;
    } t_out_item;

    localparam logic [2:0] PHASE_NONE = 3'd0;
    localparam logic [2:0] PHASE_MIN  = 3'd1;
    localparam logic [2:0] PHASE_MAX  = 3'd6;
    localparam logic [7:0] MAG_MAX    = 8'd255;

    // Hall code {Z,Y,X} to phase 1..6; 000 and 111 are invalid
    function automatic logic [2:0] hall_to_phase(input logic [2:0] hall);
        logic [2:0] ph;
        case (hall)
            3'd1:    ph = 3'd1;
            3'd2:    ph = 3'd3;
            3'd3:    ph = 3'd2;
            3'd4:    ph = 3'd5;
            3'd5:    ph = 3'd6;
            3'd6:    ph = 3'd4;
            default: ph = PHASE_NONE;
        endcase
        return ph;
    endfunction

    // High-side coil mask {C,B,A} per phase and direction
    function automatic logic [2:0] high_mask(input logic [2:0] ph, input logic rev);
        logic [2:0] m;
        case ({ph, rev})
            4'b001_0: m = 3'b100;
            4'b001_1: m = 3'b010;
            4'b010_0: m = 3'b001;
            4'b010_1: m = 3'b010;
            4'b011_0: m = 3'b001;
            4'b011_1: m = 3'b100;
            4'b100_0: m = 3'b010;
            4'b100_1: m = 3'b100;
            4'b101_0: m = 3'b010;
            4'b101_1: m = 3'b001;
            4'b110_0: m = 3'b100;
            4'b110_1: m = 3'b001;
            default:  m = 3'b000;
        endcase
        return m;
    endfunction

    // Low-side coil mask {C,B,A} per phase and direction
    function automatic logic [2:0] low_mask(input logic [2:0] ph, input logic rev);
        logic [2:0] m;
        case ({ph, rev})
            4'b001_0: m = 3'b010;
            4'b001_1: m = 3'b100;
            4'b010_0: m = 3'b010;
            4'b010_1: m = 3'b001;
            4'b011_0: m = 3'b100;
            4'b011_1: m = 3'b001;
            4'b100_0: m = 3'b100;
            4'b100_1: m = 3'b010;
            4'b101_0: m = 3'b001;
            4'b101_1: m = 3'b010;
            4'b110_0: m = 3'b001;
            4'b110_1: m = 3'b100;
            default:  m = 3'b000;
        endcase
        return m;
    endfunction

endpackage

/* sv/bldc_hall_commutation_speed.sv */
// ----------------------------------------------------------------------------
// bldc_hall_commutation_speed: six-step BLDC commutation with speed counting
// Decodes Hall sensors to a phase, drives the high/low side pattern and
// counts signed steps into a saturating accumulator sampled by ticks.
// ----------------------------------------------------------------------------
//
//  channel | direction | valid       | stall       | payload
//  --------+-----------+-------------+-------------+-------------------------
//  in      | input     | i_in_valid  | o_in_stall  | i_in_data  (t_in_item)
//  out     | output    | o_out_valid | i_out_stall | o_out_data (t_out_item)
//
//  One transaction per clock while o_in_stall is low. The state update
//  and the result are computed combinationally from the input and the
//  state registers, and the result is registered on acceptance.
//  A two-entry output queue (output register plus skid) keeps input
//  acceptance going while a result waits; o_in_stall is high only when
//  both entries are full, and is a pure register output.
//  Reset (i_rst_n low, synchronous) clears all state and empties the queue.
//
module bldc_hall_commutation_speed (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  bhcs_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output bhcs_pkg::t_out_item  o_out_data
);
    import bhcs_pkg::*;

    // Architectural state
    logic [7:0] r_level,    n_level;
    logic       r_dir,      n_dir;
    logic [2:0] r_phase,    n_phase;
    logic [2:0] r_prev,     n_prev;
    logic [2:0] r_low,      n_low;
    logic [7:0] r_duty_a,   n_duty_a;
    logic [7:0] r_duty_b,   n_duty_b;
    logic [7:0] r_duty_c,   n_duty_c;
    logic       r_moved,    n_moved;
    logic       r_step_rev, n_step_rev;
    logic [7:0] r_acc_mag,  n_acc_mag;
    logic       r_acc_rev,  n_acc_rev;
    logic [7:0] r_meas_mag, n_meas_mag;
    logic       r_meas_rev, n_meas_rev;

    // Output queue
    logic       r_out_valid;
    logic       r_skid_valid;
    t_out_item  r_out_data;
    t_out_item  r_skid_data;

    logic       in_acc;
    logic       out_take;
    logic       apply_pat;
    logic       report;
    logic [2:0] hmask;
    logic [2:0] fwd_next;
    logic [2:0] rev_next;
    logic       step_go;
    logic       step_dir;
    t_out_item  result;

    assign in_acc   = i_in_valid && !r_skid_valid;
    assign out_take = r_out_valid && !i_out_stall;

    assign fwd_next = (r_prev == PHASE_MAX) ? PHASE_MIN : r_prev + 3'd1;
    assign rev_next = (r_prev == PHASE_MIN) ? PHASE_MAX : r_prev - 3'd1;

    // Next-state logic for one transaction
    always_comb begin
        n_level    = r_level;
        n_dir      = r_dir;
        n_phase    = r_phase;
        n_prev     = r_prev;
        n_low      = r_low;
        n_moved    = r_moved;
        n_step_rev = r_step_rev;
        n_acc_mag  = r_acc_mag;
        n_acc_rev  = r_acc_rev;
        n_meas_mag = r_meas_mag;
        n_meas_rev = r_meas_rev;
        apply_pat  = 1'b0;
        report     = 1'b0;
        step_go    = 1'b0;
        step_dir   = 1'b0;

        case (i_in_data.op)
            OP_DRIVE: begin
                n_level   = i_in_data.drive_magnitude;
                n_dir     = i_in_data.drive_reverse;
                apply_pat = 1'b1;
            end
            OP_HALL: begin
                n_phase   = hall_to_phase(i_in_data.hall);
                apply_pat = 1'b1;
                n_prev    = n_phase;
                n_moved   = 1'b0;
                if (r_prev != PHASE_NONE && n_phase != PHASE_NONE) begin
                    if (n_phase == fwd_next) begin
                        step_go  = 1'b1;
                        step_dir = 1'b0;
                    end else if (n_phase == rev_next) begin
                        step_go  = 1'b1;
                        step_dir = 1'b1;
                    end
                end
                if (step_go) begin
                    n_moved    = 1'b1;
                    n_step_rev = step_dir;
                end
            end
            OP_TICK: begin
                n_meas_mag = r_acc_mag;
                n_meas_rev = r_acc_rev;
                n_acc_mag  = '0;
                report     = 1'b1;
            end
            default: begin
            end
        endcase

        // Sign-magnitude accumulate, saturating at full scale
        if (step_go) begin
            if (r_acc_mag == '0) begin
                n_acc_rev = step_dir;
                n_acc_mag = 8'd1;
            end else if (r_acc_rev == step_dir) begin
                if (r_acc_mag != MAG_MAX) begin
                    n_acc_mag = r_acc_mag + 8'd1;
                end
            end else begin
                n_acc_mag = r_acc_mag - 8'd1;
            end
        end

        // Six-step pattern; unknown phase kills high sides, low sides hold
        hmask    = high_mask(n_phase, n_dir);
        n_duty_a = r_duty_a;
        n_duty_b = r_duty_b;
        n_duty_c = r_duty_c;
        if (apply_pat) begin
            n_duty_a = hmask[0] ? n_level : 8'd0;
            n_duty_b = hmask[1] ? n_level : 8'd0;
            n_duty_c = hmask[2] ? n_level : 8'd0;
            if (n_phase != PHASE_NONE) begin
                n_low = low_mask(n_phase, n_dir);
            end
        end
    end

    always_comb begin
        result.a_high_duty     = n_duty_a;
        result.a_low_on        = n_low[0];
        result.b_high_duty     = n_duty_b;
        result.b_low_on        = n_low[1];
        result.c_high_duty     = n_duty_c;
        result.c_low_on        = n_low[2];
        result.phase_now       = n_phase;
        result.step_moved      = n_moved;
        result.step_reverse    = n_step_rev;
        result.speed_magnitude = n_meas_mag;
        result.speed_reverse   = n_meas_rev;
        result.speed_report    = report;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level    <= '0;
            r_dir      <= 1'b0;
            r_phase    <= PHASE_NONE;
            r_prev     <= PHASE_NONE;
            r_low      <= '0;
            r_duty_a   <= '0;
            r_duty_b   <= '0;
            r_duty_c   <= '0;
            r_moved    <= 1'b0;
            r_step_rev <= 1'b0;
            r_acc_mag  <= '0;
            r_acc_rev  <= 1'b0;
            r_meas_mag <= '0;
            r_meas_rev <= 1'b0;
        end else if (in_acc) begin
            r_level    <= n_level;
            r_dir      <= n_dir;
            r_phase    <= n_phase;
            r_prev     <= n_prev;
            r_low      <= n_low;
            r_duty_a   <= n_duty_a;
            r_duty_b   <= n_duty_b;
            r_duty_c   <= n_duty_c;
            r_moved    <= n_moved;
            r_step_rev <= n_step_rev;
            r_acc_mag  <= n_acc_mag;
            r_acc_rev  <= n_acc_rev;
            r_meas_mag <= n_meas_mag;
            r_meas_rev <= n_meas_rev;
        end
    end

    // Output register plus skid; skid only fills while the head is held
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (out_take) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= in_acc;
                end
            end else if (in_acc) begin
                if (!r_out_valid) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
            end else if (in_acc) begin
                r_out_data <= result;
            end
        end else if (in_acc) begin
            if (!r_out_valid) begin
                r_out_data <= result;
            end else begin
                r_skid_data <= result;
            end
        end
    end

    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

/* dv/bldc_hall_commutation_speed_tb.sv */
// ----------------------------------------------------------------------------
// bldc_hall_commutation_speed_tb: self-checking bench for Hall commutation
// Sends drive, Hall, tick and unused-op transactions through the valid/stall
// input and predicts every result from a bench copy of the six-step tables
// and the saturating step counter. Each output transaction is compared field
// by field, in order. A directed table comes first, then rotation-heavy
// random traffic with idle and stall bursts and one long output hold.
// ----------------------------------------------------------------------------
module bldc_hall_commutation_speed_tb;
    import bhcs_pkg::*;

    // Slowest legal run: about 1500 transactions, each with the longest sender
    // gap and the longest receiver stall, plus the long hold. The limit is
    // about ten times that run.
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 1450;
    localparam int N_DIRECTED   = 25;
    localparam int QUIET_TAIL   = 150;   // last transactions sent with no idling
    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_HOLD    = 60;
    localparam int HOLD_AT_ITEM = 500;
    localparam int SAT_RUN_LEN  = 280;   // longer than 255 steps, so it saturates
    localparam int PRINT_LIMIT  = 40;

    // Hall code {Z,Y,X} to phase, indexed by code
    localparam logic [7:0][2:0] HALL_PHASE = {3'd0, 3'd4, 3'd6, 3'd5,
                                              3'd2, 3'd3, 3'd1, 3'd0};
    // phase to the Hall code that produces it
    localparam logic [6:0][2:0] PHASE_HALL = {3'd5, 3'd4, 3'd6, 3'd2,
                                              3'd3, 3'd1, 3'd0};
    // coil masks {C,B,A}, indexed [phase][reverse]
    localparam logic [6:0][1:0][2:0] HIGH_SEL = {
        3'd1, 3'd4,  3'd1, 3'd2,  3'd4, 3'd2,  3'd4, 3'd1,
        3'd2, 3'd1,  3'd2, 3'd4,  3'd0, 3'd0};
    localparam logic [6:0][1:0][2:0] LOW_SEL = {
        3'd4, 3'd1,  3'd2, 3'd1,  3'd2, 3'd4,  3'd1, 3'd4,
        3'd1, 3'd2,  3'd4, 3'd2,  3'd0, 3'd0};

    typedef struct packed {
        t_in_item  item;
        logic      typed;   // want holds a hand-written result
        t_out_item want;
    } t_stim_row;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_data   = '0;
    logic      out_stall = 1'b0;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_data;

    bldc_hall_commutation_speed dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Commutation predictor, starts from the reset state
    // ------------------------------------------------------------------
    logic [7:0] coil_level  = '0;
    logic       coil_rev    = 1'b0;
    logic [2:0] hall_phase  = PHASE_NONE;
    logic [2:0] last_phase  = PHASE_NONE;
    logic [2:0] high_on     = '0;
    logic [2:0] low_on      = '0;
    logic       moved_flag  = 1'b0;
    logic       moved_rev   = 1'b0;
    logic [7:0] steps_mag   = '0;
    logic       steps_rev   = 1'b0;
    logic [7:0] speed_mag   = '0;
    logic       speed_rev   = 1'b0;

    int steps_counted = 0;
    int sat_hits      = 0;

    // Unknown phase: high sides off, low sides hold their last value
    task automatic select_coils();
        if (hall_phase == PHASE_NONE) begin
            high_on = 3'b000;
        end else begin
            high_on = HIGH_SEL[hall_phase][coil_rev];
            low_on  = LOW_SEL[hall_phase][coil_rev];
        end
    endtask

    task automatic commutate(input t_in_item it, output t_out_item res);
        logic [2:0] fwd_next;
        logic [2:0] rev_next;
        res = '0;
        case (it.op)
            OP_DRIVE: begin
                coil_level = it.drive_magnitude;
                coil_rev   = it.drive_reverse;
                select_coils();
            end
            OP_HALL: begin
                hall_phase = HALL_PHASE[it.hall];
                select_coils();
                // step_reverse is only touched by a counted step
                moved_flag = 1'b0;
                if (last_phase != PHASE_NONE && hall_phase != PHASE_NONE) begin
                    fwd_next = (last_phase == PHASE_MAX) ? PHASE_MIN : last_phase + 3'd1;
                    rev_next = (last_phase == PHASE_MIN) ? PHASE_MAX : last_phase - 3'd1;
                    if (hall_phase == fwd_next || hall_phase == rev_next) begin
                        moved_flag = 1'b1;
                        moved_rev  = (hall_phase == rev_next);
                        steps_counted++;
                        // sign-magnitude count: against the sign it decrements,
                        // from zero it takes the step's sign
                        if (steps_mag == '0) begin
                            steps_rev = moved_rev;
                            steps_mag = 8'd1;
                        end else if (steps_rev == moved_rev) begin
                            if (steps_mag != MAG_MAX) steps_mag = steps_mag + 8'd1;
                            else sat_hits++;
                        end else begin
                            steps_mag = steps_mag - 8'd1;
                        end
                    end
                end
                last_phase = hall_phase;
            end
            OP_TICK: begin
                // the sign of the count survives the clear
                speed_mag = steps_mag;
                speed_rev = steps_rev;
                steps_mag = '0;
                res.speed_report = 1'b1;
            end
            default: ;
        endcase
        res.a_high_duty     = high_on[0] ? coil_level : 8'd0;
        res.b_high_duty     = high_on[1] ? coil_level : 8'd0;
        res.c_high_duty     = high_on[2] ? coil_level : 8'd0;
        res.a_low_on        = low_on[0];
        res.b_low_on        = low_on[1];
        res.c_low_on        = low_on[2];
        res.phase_now       = hall_phase;
        res.step_moved      = moved_flag;
        res.step_reverse    = moved_rev;
        res.speed_magnitude = speed_mag;
        res.speed_reverse   = speed_rev;
    endtask

    // ------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------
    t_stim_row directed [N_DIRECTED];
    t_stim_row stim_q [$];
    logic [2:0] gen_phase = PHASE_NONE;   // phase the queued Hall codes lead to
    int         gen_count = 0;            // random transactions that do something

    task automatic queue_item(input t_op op, input logic [2:0] hall,
                              input logic [7:0] mag, input logic rev);
        t_stim_row r;
        r.item.op              = op;
        r.item.hall            = hall;
        r.item.drive_magnitude = mag;
        r.item.drive_reverse   = rev;
        r.typed                = 1'b0;
        r.want                 = '0;
        stim_q.push_back(r);
        if (op == OP_HALL) gen_phase = HALL_PHASE[hall];
        if (op != OP_NONE) gen_count++;
    endtask

    // Unused fields carry random junk so the block must ignore them
    task automatic queue_turn(input logic dir);
        logic [2:0] ph;
        if (gen_phase == PHASE_NONE) ph = 3'($urandom_range(1, 6));
        else if (!dir) ph = (gen_phase == PHASE_MAX) ? PHASE_MIN : gen_phase + 3'd1;
        else ph = (gen_phase == PHASE_MIN) ? PHASE_MAX : gen_phase - 3'd1;
        queue_item(OP_HALL, PHASE_HALL[ph], 8'($urandom), 1'($urandom));
    endtask

    task automatic queue_drive();
        logic [7:0] mag;
        case ($urandom_range(0, 7))
            0:       mag = 8'd0;
            1:       mag = MAG_MAX;
            default: mag = 8'($urandom);
        endcase
        queue_item(OP_DRIVE, 3'($urandom), mag, 1'($urandom));
    endtask

    task automatic queue_tick();
        queue_item(OP_TICK, 3'($urandom), 8'($urandom), 1'($urandom));
    endtask

    // Clear, then spin one way long enough to pin the counter at full scale
    task automatic queue_saturating_run(input logic dir);
        queue_tick();
        for (int k = 0; k < SAT_RUN_LEN; k++) begin
            if ($urandom_range(0, 19) == 0) queue_drive();
            queue_turn(dir);
        end
        queue_tick();
    endtask

    // ------------------------------------------------------------------
    // Input side monitor: predict on every accepted transaction
    // ------------------------------------------------------------------
    t_out_item pending_outputs [$];
    int accepted     = 0;
    int stall_cycles = 0;
    int results_seen = 0;
    int speed_reports = 0;
    int errors       = 0;
    int cycle_count  = 0;
    logic quiet_tail = 1'b0;
    logic hold_armed = 1'b0;

    always @(posedge clk) begin
        t_out_item pred;
        if (rst_n && in_valid) begin
            if (in_stall) begin
                stall_cycles++;
            end else begin
                commutate(in_data, pred);
                pending_outputs.push_back(stim_q[accepted].typed ?
                                          stim_q[accepted].want : pred);
                accepted++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output side: compare each transaction with the oldest prediction
    // ------------------------------------------------------------------
    task automatic report_error(input string msg);
        errors++;
        if (errors <= PRINT_LIMIT) $display("ERROR: %s", msg);
    endtask

    task automatic field_check(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_error($sformatf("result %0d: %s is %0d, expected %0d",
                                   results_seen, name, got, want));
    endtask

    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_outputs.size() == 0) begin
                report_error($sformatf("result %0d arrived with nothing pending",
                                       results_seen));
            end else begin
                want = pending_outputs.pop_front();
                field_check("a_high_duty",     out_data.a_high_duty,     want.a_high_duty);
                field_check("a_low_on",        8'(out_data.a_low_on),    8'(want.a_low_on));
                field_check("b_high_duty",     out_data.b_high_duty,     want.b_high_duty);
                field_check("b_low_on",        8'(out_data.b_low_on),    8'(want.b_low_on));
                field_check("c_high_duty",     out_data.c_high_duty,     want.c_high_duty);
                field_check("c_low_on",        8'(out_data.c_low_on),    8'(want.c_low_on));
                field_check("phase_now",       8'(out_data.phase_now),   8'(want.phase_now));
                field_check("step_moved",      8'(out_data.step_moved),
                            8'(want.step_moved));
                field_check("step_reverse",    8'(out_data.step_reverse),
                            8'(want.step_reverse));
                field_check("speed_magnitude", out_data.speed_magnitude,
                            want.speed_magnitude);
                field_check("speed_reverse",   8'(out_data.speed_reverse),
                            8'(want.speed_reverse));
                field_check("speed_report",    8'(out_data.speed_report),
                            8'(want.speed_report));
            end
            results_seen++;
            if (out_data.speed_report === 1'b1) speed_reports++;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: short random stall bursts, plus one long hold so the
    // two-entry output queue fills and the input side stalls
    // ------------------------------------------------------------------
    int   hold_left      = 0;
    logic long_hold_done = 1'b0;

    always @(posedge clk) begin
        if (hold_left > 1) begin
            hold_left <= hold_left - 1;
        end else if (hold_left == 1) begin
            hold_left <= 0;
            out_stall <= 1'b0;
        end else if (hold_armed && !long_hold_done) begin
            long_hold_done <= 1'b1;
            hold_left      <= LONG_HOLD;
            out_stall      <= 1'b1;
        end else if (!quiet_tail && ((cycle_count / 256) % 4 != 1) &&
                     $urandom_range(0, 6) == 0) begin
            hold_left <= $urandom_range(1, 5);
            out_stall <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d predictions still pending",
                     cycle_count, pending_outputs.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus build, reset, sender and end of run
    // ------------------------------------------------------------------
    initial begin
        t_out_item w_idle;
        t_out_item w_tick0;
        t_out_item w_ph1;
        logic      dir;
        int        len;
        int        pick;
        int        gap;
        logic      sat_fwd_done;
        logic      sat_rev_done;

        // results readable straight from the reset state
        w_idle  = '0;
        w_tick0 = '0;
        w_tick0.speed_report = 1'b1;
        // full drive forward in phase 1: C high side, B low side
        w_ph1   = '0;
        w_ph1.c_high_duty = MAG_MAX;
        w_ph1.b_low_on    = 1'b1;
        w_ph1.phase_now   = PHASE_MIN;

        //            op        hall   mag     rev      typed  want
        directed = '{
            '{'{OP_TICK,  3'd0, 8'h00, 1'b0}, 1'b1, w_tick0},  // tick straight after reset
            '{'{OP_NONE,  3'd0, 8'h00, 1'b0}, 1'b1, w_idle},   // unused op
            '{'{OP_DRIVE, 3'd0, 8'hFF, 1'b0}, 1'b1, w_idle},   // drive, phase unknown
            '{'{OP_HALL,  3'd0, 8'h00, 1'b0}, 1'b1, w_idle},   // invalid code 000
            '{'{OP_HALL,  3'd1, 8'h00, 1'b0}, 1'b1, w_ph1},    // first valid, no step
            '{'{OP_HALL,  3'd3, 8'h00, 1'b0}, 1'b0, w_idle},   // forward 1..6
            '{'{OP_HALL,  3'd2, 8'h00, 1'b0}, 1'b0, w_idle},
            '{'{OP_HALL,  3'd6, 8'h00, 1'b0}, 1'b0, w_idle},
            '{'{OP_HALL,  3'd4, 8'h00, 1'b0}, 1'b0, w_idle},
            '{'{OP_HALL,  3'd5, 8'h00, 1'b0}, 1'b0, w_idle},
            '{'{OP_HALL,  3'd1, 8'h00, 1'b0}, 1'b0, w_idle},   // wrap 6 -> 1
            '{'{OP_HALL,  3'd5, 8'h00, 1'b0}, 1'b0, w_idle},   // reverse wrap 1 -> 6
            '{'{OP_HALL,  3'd5, 8'h00, 1'b0}, 1'b0, w_idle},   // repeated phase
            '{'{OP_HALL,  3'd2, 8'h00, 1'b0}, 1'b0, w_idle},   // jump, not adjacent
            '{'{OP_DRIVE, 3'd0, 8'h00, 1'b1}, 1'b0, w_idle},   // zero duty, reverse
            '{'{OP_DRIVE, 3'd0, 8'h5A, 1'b1}, 1'b0, w_idle},
            '{'{OP_TICK,  3'd0, 8'h00, 1'b0}, 1'b0, w_idle},
            '{'{OP_HALL,  3'd7, 8'h00, 1'b0}, 1'b0, w_idle},   // invalid code 111
            '{'{OP_DRIVE, 3'd0, 8'hA5, 1'b0}, 1'b0, w_idle},   // drive, phase unknown
            '{'{OP_HALL,  3'd4, 8'h00, 1'b0}, 1'b0, w_idle},   // first valid after invalid
            '{'{OP_HALL,  3'd6, 8'h00, 1'b0}, 1'b0, w_idle},   // reverse from empty count
            '{'{OP_HALL,  3'd4, 8'h00, 1'b0}, 1'b0, w_idle},   // against the count
            '{'{OP_TICK,  3'd0, 8'h00, 1'b0}, 1'b0, w_idle},
            '{'{OP_NONE,  3'd7, 8'hFF, 1'b1}, 1'b0, w_idle},   // unused op, fields all ones
            '{'{OP_TICK,  3'd0, 8'h00, 1'b0}, 1'b0, w_idle}    // tick on a cleared count
        };
        foreach (directed[k]) begin
            stim_q.push_back(directed[k]);
            if (directed[k].item.op == OP_HALL) gen_phase = HALL_PHASE[directed[k].item.hall];
        end

        // Mostly clean rotations with random content; noise and broken
        // sequences mixed in. Two long runs drive the counter into saturation.
        gen_count    = 0;
        sat_fwd_done = 1'b0;
        sat_rev_done = 1'b0;
        while (gen_count < RANDOM_ITEMS) begin
            if (!sat_fwd_done && gen_count > 200) begin
                queue_saturating_run(1'b0);
                sat_fwd_done = 1'b1;
            end else if (!sat_rev_done && gen_count > 750) begin
                queue_saturating_run(1'b1);
                sat_rev_done = 1'b1;
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: begin
                        dir = 1'($urandom);
                        len = $urandom_range(4, 40);
                        for (int k = 0; k < len; k++) begin
                            pick = $urandom_range(0, 39);
                            if (pick == 5) dir = !dir;
                            if (pick < 3) queue_tick();
                            else if (pick < 5) queue_drive();
                            else queue_turn(dir);
                        end
                    end
                    6: begin
                        len = $urandom_range(3, 10);
                        for (int k = 0; k < len; k++)
                            queue_item(t_op'($urandom_range(0, 3)), 3'($urandom),
                                       8'($urandom), 1'($urandom));
                    end
                    7: queue_item(OP_HALL, 3'($urandom), 8'($urandom), 1'($urandom));
                    8: queue_drive();
                    default: queue_tick();
                endcase
            end
        end

        // synchronous reset
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        for (int idx = 0; idx < stim_q.size(); idx++) begin
            if (idx == HOLD_AT_ITEM) hold_armed <= 1'b1;
            if (idx == stim_q.size() - QUIET_TAIL) quiet_tail <= 1'b1;
            // idle bursts, with quiet windows and none at the tail
            if (idx < stim_q.size() - QUIET_TAIL && ((idx / 64) % 4 != 0) &&
                $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 5);
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid <= 1'b1;
            in_data  <= stim_q[idx].item;
            @(posedge clk);
            while (in_stall) @(posedge clk);
        end
        in_valid <= 1'b0;

        @(posedge clk);
        while (pending_outputs.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d transactions (%0d directed), %0d results, %0d speed reports",
                 accepted, N_DIRECTED, results_seen, speed_reports);
        $display("%0d steps counted, %0d at saturation, %0d input stall cycles, %0d errors",
                 steps_counted, sat_hits, stall_cycles, errors);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* files.f */
sv/bhcs_pkg.sv
sv/bldc_hall_commutation_speed.sv
dv/bldc_hall_commutation_speed_tb.sv
